// ===== hdl/swm_pkg.sv =====
package swm_pkg;

    // default ring depth
    localparam int HISTORY_DEPTH_DEF = 32;

    localparam int BAND_W      = 16;
    localparam int NUM_BANDS   = 8;
    localparam int STAMP_W     = 32;
    localparam int VIS_W       = 19;
    localparam int SHARE_W     = 17;
    localparam int SPREAD_W    = 12;
    localparam int COUNT_OUT_W = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 192;
    localparam int OUT_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NIR_SHARE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHARE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHARE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_CEIL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS     = 3'd6;

    // reset values
    localparam logic [BAND_W-1:0]   RST_CLEAR_FLOOR   = 16'd200;
    localparam logic [VIS_W-1:0]    RST_VISIBLE_FLOOR = 19'd300;
    localparam logic [SHARE_W-1:0]  RST_NIR_SHARE     = 17'd9831;
    localparam logic [SHARE_W-1:0]  RST_RED_SHARE     = 17'd11797;
    localparam logic [SHARE_W-1:0]  RST_BLUE_SHARE    = 17'd5243;
    localparam logic [SPREAD_W-1:0] RST_SPREAD_CEIL   = 12'd160;
    localparam logic [STAMP_W-1:0]  RST_WINDOW_MS     = 32'd60000;

    typedef struct packed {
        logic [BAND_W-1:0]   clear_floor;
        logic [VIS_W-1:0]    visible_floor;
        logic [SHARE_W-1:0]  nir_share_floor;
        logic [SHARE_W-1:0]  red_share_floor;
        logic [SHARE_W-1:0]  blue_share_floor;
        logic [SPREAD_W-1:0] spread_ceiling;
        logic [STAMP_W-1:0]  window_length_ms;
    } t_cfg;

    typedef struct packed {
        logic [NUM_BANDS-1:0][BAND_W-1:0] band;
        logic [BAND_W-1:0]                clear_level;
        logic [BAND_W-1:0]                nir_level;
    } t_reading;

    typedef struct packed {
        logic vld;
        logic strict;
    } t_verdict;

    typedef struct packed {
        logic                   vld;
        logic                   vote;
        logic                   strict;
        logic [COUNT_OUT_W-1:0] total;
        logic [COUNT_OUT_W-1:0] hits;
    } t_vote;

endpackage

// ===== hdl/swm_judge.sv =====
module swm_judge
    import swm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_reading i_reading,
    input  t_cfg     i_cfg,
    output t_verdict o_verdict
);

    logic [3:0]          r_vld;
    t_reading            r_rd;

    // stage 1: sums and band extremes
    logic [VIS_W-1:0]    n_vis;
    logic [BAND_W-1:0]   n_lo;
    logic [BAND_W-1:0]   n_hi;
    logic [VIS_W-1:0]    r_vis;
    logic [BAND_W+1:0]   r_blue;
    logic [BAND_W:0]     r_red;
    logic [BAND_W-1:0]   r_nir;
    logic [BAND_W-1:0]   r_lo;
    logic [BAND_W-1:0]   r_hi;
    logic                r_ok1;

    // stage 2: cross products
    logic [35:0]         r_nir_rhs;
    logic [35:0]         r_red_rhs;
    logic [35:0]         r_blue_rhs;
    logic [27:0]         r_spr_rhs;
    logic [31:0]         r_nir_lhs;
    logic [32:0]         r_red_lhs;
    logic [33:0]         r_blue_lhs;
    logic [19:0]         r_spr_lhs;
    logic                r_ok2;

    logic                r_strict;

    always_comb begin
        n_vis = '0;
        n_lo  = r_rd.band[0];
        n_hi  = r_rd.band[0];
        for (int i = 0; i < NUM_BANDS; i++) begin
            n_vis = n_vis + VIS_W'(r_rd.band[i]);
            if (r_rd.band[i] < n_lo) n_lo = r_rd.band[i];
            if (r_rd.band[i] > n_hi) n_hi = r_rd.band[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd <= i_reading;
        end
        r_vis  <= n_vis;
        r_blue <= (BAND_W+2)'(r_rd.band[0]) + (BAND_W+2)'(r_rd.band[1])
                + (BAND_W+2)'(r_rd.band[2]);
        r_red  <= (BAND_W+1)'(r_rd.band[6]) + (BAND_W+1)'(r_rd.band[7]);
        r_nir  <= r_rd.nir_level;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_ok1  <= (r_rd.clear_level >= i_cfg.clear_floor) && (n_lo != '0);

        r_ok2      <= r_ok1 && (r_vis >= i_cfg.visible_floor);
        r_nir_rhs  <= 36'(i_cfg.nir_share_floor) * 36'(r_vis);
        r_red_rhs  <= 36'(i_cfg.red_share_floor) * 36'(r_vis);
        r_blue_rhs <= 36'(i_cfg.blue_share_floor) * 36'(r_vis);
        r_spr_rhs  <= 28'(i_cfg.spread_ceiling) * 28'(r_lo);
        r_nir_lhs  <= {r_nir, 16'b0};
        r_red_lhs  <= {r_red, 16'b0};
        r_blue_lhs <= {r_blue, 16'b0};
        r_spr_lhs  <= {r_hi, 4'b0};

        r_strict <= r_ok2
            && (36'(r_nir_lhs) >= r_nir_rhs)
            && (36'(r_red_lhs) >= r_red_rhs)
            && (36'(r_blue_lhs) >= r_blue_rhs)
            && (28'(r_spr_lhs) <= r_spr_rhs);
    end

    assign o_verdict.vld    = r_vld[3];
    assign o_verdict.strict = r_strict;

endmodule

// ===== hdl/swm_ring.sv =====
module swm_ring
    import swm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [STAMP_W-1:0] i_window,
    input  t_verdict           i_verdict,
    input  logic               i_out_free,
    output logic               o_idle,
    output t_vote              o_res
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int XW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT, ST_DONE} t_state;

    t_state             r_state;
    logic [AW-1:0]      r_slot;
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_addr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [STAMP_W-1:0] r_now;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_hits;
    logic               r_have;
    logic               r_strict;

    // verdict in the top bit, stamp below
    logic [STAMP_W:0]   r_mem [HISTORY_DEPTH];
    logic [STAMP_W:0]   r_q;

    logic               mem_re;
    logic               mem_we;
    logic [STAMP_W-1:0] age;
    logic               in_window;
    logic [CW-1:0]      tot;
    logic [CW-1:0]      hits;
    logic [XW-1:0]      tot_x;
    logic [XW-1:0]      hits_x;

    assign mem_re = (r_state == ST_SCAN) && (r_addr < r_fill);
    assign mem_we = (r_state == ST_DONE) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= {r_strict, r_now};
        end
        if (mem_re) begin
            r_q <= r_mem[r_addr[AW-1:0]];
        end
    end

    // the slot about to be overwritten drops out of the count
    assign age       = r_now - r_q[STAMP_W-1:0];
    assign in_window = r_rd_vld && (r_rd_idx != r_slot)
                    && (r_now >= r_q[STAMP_W-1:0]) && (age <= i_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_slot   <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_now   <= i_stamp;
                        r_addr  <= '0;
                        r_total <= '0;
                        r_hits  <= '0;
                        r_have  <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (mem_re) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (!mem_re && !r_rd_vld) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (r_have) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                        r_slot  <= (r_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                        if (r_fill != CW'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            r_rd_vld <= mem_re;
            r_rd_idx <= r_addr[AW-1:0];
            if (in_window) begin
                r_total <= r_total + 1'b1;
                if (r_q[STAMP_W]) begin
                    r_hits <= r_hits + 1'b1;
                end
            end
            if (i_verdict.vld) begin
                r_have   <= 1'b1;
                r_strict <= i_verdict.strict;
            end
        end
    end

    // the new reading always counts: age zero
    assign tot    = r_total + 1'b1;
    assign hits   = r_hits + CW'(r_strict);
    assign tot_x  = XW'(tot);
    assign hits_x = XW'(hits);

    assign o_idle       = (r_state == ST_IDLE);
    assign o_res.vld    = (r_state == ST_DONE);
    assign o_res.vote   = ({hits, 1'b0} >= {1'b0, tot});
    assign o_res.strict = r_strict;
    assign o_res.total  = tot_x[COUNT_OUT_W-1:0];
    assign o_res.hits   = hits_x[COUNT_OUT_W-1:0];

endmodule

// ===== hdl/sunlight_window_majority.sv =====
// sunlight window majority vote
//
// input stream: one spectral reading per item on s_axis; eight band counts,
// clear and nir counts and a millisecond stamp. output stream: one result
// item per reading on m_axis with the majority vote, this reading's own
// verdict and the counts of recent and strict-recent entries.
// configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we high,
// only while no item is in flight.
// timing: the time from accept to result is set by the scan of the history
// ring through its single read port and grows with the ring fill; the
// verdict pipeline runs in parallel with the scan. one item is processed
// at a time and s_axis_tready is high only while the engine is idle.
// stall: the result sits in an output register; the engine takes the next
// item while it waits, but holds its own result until that register frees.
// reset: synchronous active low; registers return to defaults and the ring
// is empty (fill count zero), no clearing pass is needed.
module sunlight_window_majority
    import swm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // band_0..band_7, clear_level, nir_level (16 b each), stamp_ms (32 b)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sunny_vote, strict_now, recent_total (6 b), recent_strict (6 b), pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    t_reading              reading;
    t_verdict              verdict;
    t_vote                 res;
    logic                  start;
    logic                  idle;
    logic                  out_free;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clear_floor      <= RST_CLEAR_FLOOR;
            r_cfg.visible_floor    <= RST_VISIBLE_FLOOR;
            r_cfg.nir_share_floor  <= RST_NIR_SHARE;
            r_cfg.red_share_floor  <= RST_RED_SHARE;
            r_cfg.blue_share_floor <= RST_BLUE_SHARE;
            r_cfg.spread_ceiling   <= RST_SPREAD_CEIL;
            r_cfg.window_length_ms <= RST_WINDOW_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLEAR_FLOOR:   r_cfg.clear_floor      <= i_cfg_data[BAND_W-1:0];
                REG_VISIBLE_FLOOR: r_cfg.visible_floor    <= i_cfg_data[VIS_W-1:0];
                REG_NIR_SHARE:     r_cfg.nir_share_floor  <= i_cfg_data[SHARE_W-1:0];
                REG_RED_SHARE:     r_cfg.red_share_floor  <= i_cfg_data[SHARE_W-1:0];
                REG_BLUE_SHARE:    r_cfg.blue_share_floor <= i_cfg_data[SHARE_W-1:0];
                REG_SPREAD_CEIL:   r_cfg.spread_ceiling   <= i_cfg_data[SPREAD_W-1:0];
                REG_WINDOW_MS:     r_cfg.window_length_ms <= i_cfg_data[STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the reading, band_0 in the lowest bits
    always_comb begin
        for (int i = 0; i < NUM_BANDS; i++) begin
            reading.band[i] = s_axis_tdata[i*BAND_W +: BAND_W];
        end
        reading.clear_level = s_axis_tdata[NUM_BANDS*BAND_W +: BAND_W];
        reading.nir_level   = s_axis_tdata[(NUM_BANDS+1)*BAND_W +: BAND_W];
    end

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign out_free      = !r_m_valid || m_axis_tready;

    swm_judge u_judge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_reading (reading),
        .i_cfg     (r_cfg),
        .o_verdict (verdict)
    );

    swm_ring #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_stamp    (s_axis_tdata[(NUM_BANDS+2)*BAND_W +: STAMP_W]),
        .i_window   (r_cfg.window_length_ms),
        .i_verdict  (verdict),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_res      (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res.vld && out_free) begin
            r_m_valid <= 1'b1;
            r_m_data  <= {2'b00, res.hits, res.total, res.strict, res.vote};
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== hdl/swm_checker.sv =====
module swm_checker
    import swm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready
);

    // one item in flight at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed under stall");

    // reset empties the output and reopens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("bad state after reset");

    // a new result only comes out of a busy engine
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without work");

endmodule

bind sunlight_window_majority swm_checker u_swm_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
    import swm_pkg::*;

    // spare register index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int RING_DEPTH       = 32;
    localparam int SETTLE_CYCLES    = 40;     // full ring scan plus verdict pipe
    localparam int HOLD_OFF_CYCLES  = 400;    // long receiver stall, fills the block
    localparam int ITEMS_PER_PHASE  = 117;
    localparam int RANDOM_PHASES    = 6;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // one spectral reading as the block sees it
    typedef struct {
        logic [NUM_BANDS-1:0][BAND_W-1:0] band;
        logic [BAND_W-1:0]                clear_level;
        logic [BAND_W-1:0]                nir_level;
        logic [STAMP_W-1:0]               stamp_ms;
    } sample_t;

    // one vote item from the block
    typedef struct {
        logic                   sunny_vote;
        logic                   strict_now;
        logic [COUNT_OUT_W-1:0] recent_total;
        logic [COUNT_OUT_W-1:0] recent_strict;
    } result_t;

    // a row of the directed table: either a reading or a register write
    typedef struct {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        sample_t                rd;
        logic                   typed;
        result_t                want;
    } plan_row_t;

    // clock and block inputs, all known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the registers
    logic [BAND_W-1:0]   cfg_clear   = RST_CLEAR_FLOOR;
    logic [VIS_W-1:0]    cfg_visible = RST_VISIBLE_FLOOR;
    logic [SHARE_W-1:0]  cfg_nir     = RST_NIR_SHARE;
    logic [SHARE_W-1:0]  cfg_red     = RST_RED_SHARE;
    logic [SHARE_W-1:0]  cfg_blue    = RST_BLUE_SHARE;
    logic [SPREAD_W-1:0] cfg_spread  = RST_SPREAD_CEIL;
    logic [STAMP_W-1:0]  cfg_window  = RST_WINDOW_MS;

    // predictor copy of the history ring
    logic [STAMP_W-1:0] stamp_mem [RING_DEPTH];
    logic               verdict_mem [RING_DEPTH];
    int unsigned        ring_slot = 0;
    int unsigned        ring_fill = 0;

    // votes still owed by the block, oldest first
    result_t   expected_votes [$];
    plan_row_t plan [$];

    logic [STAMP_W-1:0] stamp_cursor = '0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    bit  hold_off_req = 1'b0;
    int  err_count = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_strict = 0;
    int  n_votes = 0;
    int  n_reg_writes = 0;

    sunlight_window_majority u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),   // band_0..band_7, clear, nir, stamp_ms
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // vote, strict, total, strict count, pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // all eight bands at one level
    function automatic sample_t flat(int unsigned level, int unsigned clr,
                                     int unsigned nir, logic [STAMP_W-1:0] stamp);
        sample_t s;
        for (int k = 0; k < NUM_BANDS; k++) s.band[k] = level[BAND_W-1:0];
        s.clear_level = clr[BAND_W-1:0];
        s.nir_level   = nir[BAND_W-1:0];
        s.stamp_ms    = stamp;
        return s;
    endfunction

    // classify the reading, store it in the ring and count the window
    function automatic result_t forecast_vote(sample_t s);
        longint unsigned vis, lo, hi, blue, red, nir_sh;
        logic            strict;
        logic [STAMP_W-1:0] t_now, t_old;
        int unsigned     total, hits;
        result_t         r;
        vis = 0;
        lo  = s.band[0];
        hi  = s.band[0];
        for (int k = 0; k < NUM_BANDS; k++) begin
            vis += s.band[k];
            if (s.band[k] < lo) lo = s.band[k];
            if (s.band[k] > hi) hi = s.band[k];
        end
        blue   = longint'(s.band[0]) + s.band[1] + s.band[2];
        red    = longint'(s.band[6]) + s.band[7];
        nir_sh = longint'(s.nir_level);
        // shares and spread by cross multiplication, exact in 64 bits
        strict = (s.clear_level >= cfg_clear) && (vis >= cfg_visible) && (lo != 0)
              && ((nir_sh << 16) >= longint'(cfg_nir) * vis)
              && ((red << 16) >= longint'(cfg_red) * vis)
              && ((blue << 16) >= longint'(cfg_blue) * vis)
              && (hi * 16 <= longint'(cfg_spread) * lo);

        t_now = s.stamp_ms;
        stamp_mem[ring_slot]   = t_now;
        verdict_mem[ring_slot] = strict;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;

        total = 0;
        hits  = 0;
        for (int k = 0; k < ring_fill; k++) begin
            t_old = stamp_mem[k];
            // entries from the future or older than the window are skipped
            if (t_now < t_old || (t_now - t_old) > cfg_window) continue;
            total++;
            if (verdict_mem[k]) hits++;
        end
        r.sunny_vote    = (total > 0) && (hits * 2 >= total);
        r.strict_now    = strict;
        r.recent_total  = total[COUNT_OUT_W-1:0];
        r.recent_strict = hits[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // random reading: mostly sun-like with random content, some spoiled, some noise
    function automatic sample_t make_reading(int unsigned step_max);
        sample_t         s;
        int              r, k;
        int unsigned     base;
        longint unsigned v, vis;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            for (k = 0; k < NUM_BANDS; k++) s.band[k] = $urandom;
            s.clear_level = $urandom;
            s.nir_level   = $urandom;
            s.stamp_ms    = $urandom;
            return s;
        end
        base = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 50000)
                                           : $urandom_range(1, 5000);
        for (k = 0; k < NUM_BANDS; k++) begin
            v = base + $urandom_range(0, base / 2);
            s.band[k] = (v > 65535) ? 16'hFFFF : v[BAND_W-1:0];
        end
        // pull the red bands down toward the share floor now and then
        if ($urandom_range(0, 3) == 0) begin
            for (k = 6; k < 8; k++) begin
                v = longint'(base) * $urandom_range(40, 80) / 100;
                s.band[k] = (v == 0) ? 16'd1 : v[BAND_W-1:0];
            end
        end
        vis = 0;
        for (k = 0; k < NUM_BANDS; k++) vis += s.band[k];
        v = vis * $urandom_range(120, 200) / 1000;
        s.nir_level   = (v > 65535) ? 16'hFFFF : v[BAND_W-1:0];
        s.clear_level = $urandom_range(150, 65535);
        // spoiled reading: one test broken on purpose
        if (r < 30) begin
            k = $urandom_range(0, NUM_BANDS - 1);
            case ($urandom_range(0, 3))
                0: s.band[k] = '0;
                1: s.clear_level = $urandom_range(0, 199);
                2: begin
                    v = longint'(s.band[k]) * $urandom_range(11, 20);
                    s.band[k] = (v > 65535) ? 16'hFFFF : v[BAND_W-1:0];
                end
                default: s.nir_level = s.nir_level / 4;
            endcase
        end
        // stamps walk forward, with an occasional step back
        if ($urandom_range(0, 19) == 0) stamp_cursor -= $urandom_range(1, step_max);
        else stamp_cursor += $urandom_range(0, step_max);
        s.stamp_ms = stamp_cursor;
        return s;
    endfunction

    task automatic add_item(sample_t s);
        plan_row_t row;
        row.kind  = ROW_ITEM;
        row.rd    = s;
        row.typed = 1'b0;
        row.want  = '{default: '0};
        plan.push_back(row);
    endtask

    task automatic add_typed(sample_t s, result_t want);
        plan_row_t row;
        row.kind  = ROW_ITEM;
        row.rd    = s;
        row.typed = 1'b1;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed   = 1'b0;
        row.rd      = flat(0, 0, 0, 0);
        row.want    = '{default: '0};
        plan.push_back(row);
    endtask

    // one register write; predictor copy is masked to the register width
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CLEAR_FLOOR:   cfg_clear   = val[BAND_W-1:0];
            REG_VISIBLE_FLOOR: cfg_visible = val[VIS_W-1:0];
            REG_NIR_SHARE:     cfg_nir     = val[SHARE_W-1:0];
            REG_RED_SHARE:     cfg_red     = val[SHARE_W-1:0];
            REG_BLUE_SHARE:    cfg_blue    = val[SHARE_W-1:0];
            REG_SPREAD_CEIL:   cfg_spread  = val[SPREAD_W-1:0];
            REG_WINDOW_MS:     cfg_window  = val[STAMP_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
        @(posedge i_clk);
    endtask

    // offer one reading until it is taken, then log the vote it must cause
    task automatic push_item(sample_t s, logic typed, result_t want);
        int      gap;
        result_t guess;
        logic [IN_DATA_W-1:0] d;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int k = 0; k < NUM_BANDS; k++) d[k*BAND_W +: BAND_W] = s.band[k];
        d[128 +: BAND_W]  = s.clear_level;
        d[144 +: BAND_W]  = s.nir_level;
        d[160 +: STAMP_W] = s.stamp_ms;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        guess = forecast_vote(s);
        expected_votes.push_back(typed ? want : guess);
        n_items++;
    endtask

    // stop offering, let every vote come out and the engine go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_votes.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register set for each random phase, extremes among them
    task automatic load_setting(int ph);
        case (ph)
            0: begin
                write_reg(REG_CLEAR_FLOOR,   RST_CLEAR_FLOOR);
                write_reg(REG_VISIBLE_FLOOR, RST_VISIBLE_FLOOR);
                write_reg(REG_NIR_SHARE,     RST_NIR_SHARE);
                write_reg(REG_RED_SHARE,     RST_RED_SHARE);
                write_reg(REG_BLUE_SHARE,    RST_BLUE_SHARE);
                write_reg(REG_SPREAD_CEIL,   RST_SPREAD_CEIL);
                write_reg(REG_WINDOW_MS,     RST_WINDOW_MS);
            end
            2: begin
                // all floors at zero, window of zero counts only equal stamps
                write_reg(REG_CLEAR_FLOOR,   '0);
                write_reg(REG_VISIBLE_FLOOR, '0);
                write_reg(REG_NIR_SHARE,     '0);
                write_reg(REG_RED_SHARE,     '0);
                write_reg(REG_BLUE_SHARE,    '0);
                write_reg(REG_SPREAD_CEIL,   '0);
                write_reg(REG_WINDOW_MS,     '0);
            end
            3: begin
                write_reg(REG_CLEAR_FLOOR,   32'd65535);
                write_reg(REG_VISIBLE_FLOOR, 32'd524280);
                write_reg(REG_NIR_SHARE,     32'd65536);
                write_reg(REG_RED_SHARE,     32'd65536);
                write_reg(REG_BLUE_SHARE,    32'd65536);
                write_reg(REG_SPREAD_CEIL,   32'd4095);
                write_reg(REG_WINDOW_MS,     32'hFFFF_FFFF);
            end
            default: begin
                write_reg(REG_CLEAR_FLOOR,   $urandom_range(0, 1000));
                write_reg(REG_VISIBLE_FLOOR, $urandom_range(0, 5000));
                write_reg(REG_NIR_SHARE,     $urandom_range(5000, 15000));
                write_reg(REG_RED_SHARE,     $urandom_range(8000, 16000));
                write_reg(REG_BLUE_SHARE,    $urandom_range(3000, 8000));
                write_reg(REG_SPREAD_CEIL,   $urandom_range(32, 400));
                write_reg(REG_WINDOW_MS,     $urandom_range(1000, 200000));
            end
        endcase
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each vote item with the oldest expectation
    always @(posedge i_clk) begin : vote_check
        result_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sunny_vote    = m_axis_tdata[0];
            got.strict_now    = m_axis_tdata[1];
            got.recent_total  = m_axis_tdata[7:2];
            got.recent_strict = m_axis_tdata[13:8];
            if (expected_votes.size() == 0) begin
                $error("vote item with nothing expected: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                want = expected_votes.pop_front();
                if (got.sunny_vote !== want.sunny_vote) begin
                    $error("sunny_vote expected %0d got %0d", want.sunny_vote,
                           got.sunny_vote);
                    err_count++;
                end
                if (got.strict_now !== want.strict_now) begin
                    $error("strict_now expected %0d got %0d", want.strict_now,
                           got.strict_now);
                    err_count++;
                end
                if (got.recent_total !== want.recent_total) begin
                    $error("recent_total expected %0d got %0d", want.recent_total,
                           got.recent_total);
                    err_count++;
                end
                if (got.recent_strict !== want.recent_strict) begin
                    $error("recent_strict expected %0d got %0d", want.recent_strict,
                           got.recent_strict);
                    err_count++;
                end
                n_results++;
                if (got.strict_now) n_strict++;
                if (got.sunny_vote) n_votes++;
            end
        end
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        sample_t     s;
        int unsigned step_max;
        result_t     none;
        none = '{default: '0};

        // directed table, run under the reset register values first
        // empty ring, all-zero reading: one entry counted, nothing strict
        add_typed(flat(0, 0, 0, 0), '{1'b0, 1'b0, 6'd1, 6'd0});
        // bands, clear and nir at their top: nir share below floor, still not strict
        add_typed(flat(65535, 65535, 65535, 0), '{1'b0, 1'b0, 6'd2, 6'd0});
        add_item(flat(1000, 1000, 2000, 100));          // clean sun reading
        add_item(flat(1000, 1000, 2000, 200));          // half strict, vote flips
        s = flat(1000, 1000, 2000, 300);
        s.band[4] = '0;                                  // zero band kills verdict
        add_item(s);
        s = flat(500, 1000, 1000, 400);
        s.band[0] = 16'd100;
        s.band[7] = 16'd1000;                            // spread exactly at ceiling
        add_item(s);
        s.band[7] = 16'd1001;                            // one past the ceiling
        s.stamp_ms = 500;
        add_item(s);
        add_item(flat(8192, 1000, 9831, 600));          // nir share exactly at floor
        add_item(flat(8192, 1000, 9830, 700));          // one below
        add_item(flat(1000, 199, 2000, 800));           // clear one below floor
        add_item(flat(1000, 200, 2000, 900));           // clear at floor
        add_item(flat(1000, 1000, 2000, 60100));        // oldest kept entry at window edge
        add_item(flat(1000, 1000, 2000, 60101));        // and just past it
        add_item(flat(1000, 1000, 2000, 50));           // stamp goes back, future entries
        add_item(flat(1000, 1000, 2000, 32'hFFFF_FFFF));
        add_item(flat(1000, 1000, 2000, 5));            // stamp wraps
        // zero visible sum with the visible floor at zero
        add_cfg(REG_VISIBLE_FLOOR, '0);
        add_cfg(REG_CLEAR_FLOOR, '0);
        add_item(flat(0, 0, 0, 10));
        s = flat(0, 0, 0, 11);
        s.band[3] = 16'hFFFF;
        add_item(s);
        // oversized writes are cut to width, the spare index is ignored
        add_cfg(REG_CLEAR_FLOOR, 32'hFFFF_FFFF);
        add_cfg(REG_SPREAD_CEIL, 32'hFFFF_FFFF);
        add_cfg(REG_SPARE, 32'h1234_5678);
        add_item(flat(1000, 65535, 2000, 12));
        // full shares demanded
        add_cfg(REG_NIR_SHARE, 32'd65536);
        add_cfg(REG_RED_SHARE, 32'd65536);
        add_cfg(REG_BLUE_SHARE, 32'd65536);
        add_item(flat(1000, 65535, 65535, 13));
        // zero window: only entries with the same stamp count
        add_cfg(REG_WINDOW_MS, '0);
        add_item(flat(1000, 65535, 2000, 13));
        add_item(flat(1000, 65535, 2000, 14));
        add_cfg(REG_WINDOW_MS, 32'hFFFF_FFFF);
        add_cfg(REG_VISIBLE_FLOOR, 32'd524280);
        add_item(flat(65535, 65535, 65535, 15));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                push_item(plan[k].rd, plan[k].typed, plan[k].want);
            end
        end

        // random phases, one register set each
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            load_setting(ph);
            if (cfg_window == 0) step_max = 2;
            else if (cfg_window > 32'h4000_0000) step_max = 50000;
            else step_max = cfg_window / 12 + 1;
            stamp_cursor = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    tx_calm = (ph == 4) || ($urandom_range(0, 4) == 0);
                    rx_calm = (ph == 4) || ($urandom_range(0, 4) == 0);
                    // long receiver hold-off while the sender keeps offering
                    if (ph == 1 && n == 0) begin
                        tx_calm = 1'b1;
                        hold_off_req = 1'b1;
                    end
                end
                push_item(make_reading(step_max), 1'b0, none);
            end
        end

        settle();
        if (expected_votes.size() != 0) begin
            $error("%0d vote items never arrived", expected_votes.size());
            err_count++;
        end
        $display("covered %0d readings and %0d votes over %0d register writes",
                 n_items, n_results, n_reg_writes);
        $display("saw %0d strict verdicts and %0d positive votes", n_strict, n_votes);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
